// ----- rtl/kls_pkg.sv -----
package kls_pkg;

  localparam int unsigned MAX_RANK = 64;
  localparam int unsigned RANK_W   = $clog2(MAX_RANK + 1);
  localparam int unsigned IDX_W    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CFG_W    = 7;

  typedef enum logic {
    KIND_PRELOAD = 1'b0,
    KIND_ADD     = 1'b1
  } kind_e;

  // what one cell hands to the next one down the chain
  typedef struct packed {
    logic                      valid;
    logic                      ge;
    logic signed [VALUE_W-1:0] value;
  } kls_link_t;

endpackage

// ----- rtl/kls_if.sv -----
interface kls_in_if;
  import kls_pkg::*;
  logic                      valid;
  logic                      ready;
  kind_e                     kind;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface kls_out_if;
  import kls_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] kth_value;
  logic                      enough_held;

  modport source (output valid, output kth_value, output enough_held, input ready);
  modport sink (input valid, input kth_value, input enough_held, output ready);
endinterface

// ----- rtl/kls_cell.sv -----
module kls_cell
  import kls_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic                      in_range_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  kls_link_t                 prev_i,
  output kls_link_t                 link_o
);

  logic                      vld_q, vld_d;
  logic signed [VALUE_W-1:0] val_q, val_d;
  logic                      ge;

  assign ge = vld_q && in_range_i && (val_q >= value_i);

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    if (load_i) begin
      vld_d = in_range_i && (vld_q || prev_i.valid);
      if (!ge) begin
        val_d = prev_i.ge ? value_i : prev_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o.valid = vld_q;
  assign link_o.ge    = ge;
  assign link_o.value = val_q;

endmodule

// ----- rtl/kls_pick.sv -----
module kls_pick
  import kls_pkg::*;
(
  input  logic [MAX_RANK-1:0]              vld_i,
  input  logic signed [VALUE_W-1:0]        val_i [MAX_RANK],
  input  logic [RANK_W-1:0]                rank_i,
  output logic signed [VALUE_W-1:0]        kth_value_o,
  output logic                             enough_held_o
);

  logic [MAX_RANK-1:0] sel;
  logic [RANK_W-1:0]   last;

  // the last valid cell holds the smallest kept value
  always_comb begin
    for (int i = 0; i < MAX_RANK; i++) begin
      if (i == MAX_RANK - 1) begin
        sel[i] = vld_i[i];
      end else begin
        sel[i] = vld_i[i] && !vld_i[i+1];
      end
    end
  end

  always_comb begin
    kth_value_o = '0;
    for (int i = 0; i < MAX_RANK; i++) begin
      kth_value_o = kth_value_o | (sel[i] ? val_i[i] : '0);
    end
  end

  assign last          = rank_i - RANK_W'(1);
  assign enough_held_o = vld_i[last[IDX_W-1:0]];

endmodule

// ----- rtl/kth_largest_stream_tracker.sv -----
// Keeps the rank_k largest signed 32-bit values in a row of MAX_RANK cells sorted from largest to
// smallest; each word is compared against every cell at once and slots in with one shift, so a
// word is accepted every cycle while the result side takes each result as it comes; a result
// left waiting holds the input back. An add word gives its result, taken from the last occupied
// cell, once the cells and then the output register have been loaded, while a preload word gives
// none. rank_k of zero acts as one and values above MAX_RANK act as MAX_RANK; lowering it drops
// the smallest entries at the next word. Write rank_k only while the block is idle.
module kth_largest_stream_tracker
  import kls_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  kls_in_if.sink           in_i,
  kls_out_if.source        out_o
);

  logic [CFG_W-1:0]          rank_q;
  logic [RANK_W-1:0]         rank_eff;
  logic                      in_acc;
  logic                      pend_q, pend_d;
  logic                      out_vld_q, out_vld_d;
  logic                      out_load;
  logic signed [VALUE_W-1:0] out_val_q;
  logic                      out_enough_q;
  logic signed [VALUE_W-1:0] pick_val;
  logic                      pick_enough;
  kls_link_t                 links [MAX_RANK+1];
  logic [MAX_RANK-1:0]       cell_vld;
  logic signed [VALUE_W-1:0] cell_val [MAX_RANK];

  always_comb begin
    if (rank_q == '0) begin
      rank_eff = RANK_W'(1);
    end else if (32'(rank_q) > MAX_RANK) begin
      rank_eff = RANK_W'(MAX_RANK);
    end else begin
      rank_eff = RANK_W'(rank_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      rank_q <= cfg_wdata_i;
    end
  end

  assign out_load    = pend_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !pend_q || out_load;
  assign in_acc      = in_i.valid && in_i.ready;

  // top of the chain always hands in the new word
  assign links[0].valid = 1'b1;
  assign links[0].ge    = 1'b1;
  assign links[0].value = '0;

  for (genvar g = 0; g < MAX_RANK; g++) begin : g_cell
    kls_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (in_acc),
      .in_range_i (32'(g) < 32'(rank_eff)),
      .value_i    (in_i.value),
      .prev_i     (links[g]),
      .link_o     (links[g+1])
    );
    assign cell_vld[g] = links[g+1].valid;
    assign cell_val[g] = links[g+1].value;
  end

  kls_pick u_pick (
    .vld_i         (cell_vld),
    .val_i         (cell_val),
    .rank_i        (rank_eff),
    .kth_value_o   (pick_val),
    .enough_held_o (pick_enough)
  );

  always_comb begin
    pend_d = pend_q;
    if (out_load) begin
      pend_d = 1'b0;
    end
    if (in_acc) begin
      pend_d = (in_i.kind == KIND_ADD);
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q    <= pick_val;
      out_enough_q <= pick_enough;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.kth_value   = out_val_q;
  assign out_o.enough_held = out_enough_q;

  // occupied cells always form a prefix of the chain
  a_vld_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_vld >> 1) & ~cell_vld) == '0)
    else $error("gap in occupied cells");

  a_add_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.kind == KIND_ADD) |=> pend_q)
    else $error("add word left no pending result");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_vld_q)
    else $error("result load did not raise valid");

  a_pend_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> cell_vld[0])
    else $error("result pending with empty store");

endmodule
